/* src/cart_header_validator_assert.svh */
// ----------------------------------------------------------------------------
// Header validator assertion macros
// Shared concurrent assertion forms, clocked on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef CART_HEADER_VALIDATOR_ASSERT_SVH
`define CART_HEADER_VALIDATOR_ASSERT_SVH

// same-cycle implication
`define CHV_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CHV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/chv_pkg.sv */
// ----------------------------------------------------------------------------
// Header validator package
// Types, codes and the logo table shared by the validator modules.
// ----------------------------------------------------------------------------
package chv_pkg;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_LOGO     = 3'd1,
      STATUS_CHECKSUM = 3'd2,
      STATUS_ROM_CODE = 3'd3,
      STATUS_RAM_CODE = 3'd4,
      STATUS_RAM_CONF = 3'd5
   } status_type;

   // header offsets (address minus 0x100)
   localparam logic [6:0] IDX_LOGO_FIRST  = 7'h04;
   localparam logic [6:0] IDX_LOGO_LAST   = 7'h33;
   localparam logic [6:0] IDX_SUM_FIRST   = 7'h34;
   localparam logic [6:0] IDX_SUM_LAST    = 7'h4C;
   localparam logic [6:0] IDX_COLOR       = 7'h43;
   localparam logic [6:0] IDX_KIND        = 7'h47;
   localparam logic [6:0] IDX_ROM_CODE    = 7'h48;
   localparam logic [6:0] IDX_RAM_CODE    = 7'h49;
   localparam logic [6:0] IDX_STORED_SUM  = 7'h4D;

   localparam logic [7:0] KIND_MBC2       = 8'h06;
   localparam logic [7:0] KIND_MBC7       = 8'h22;

   localparam logic [7:0] ROM_CODE_MAX    = 8'h08;
   localparam logic [7:0] ROM_CODE_72     = 8'h52;
   localparam logic [7:0] ROM_CODE_80     = 8'h53;
   localparam logic [7:0] ROM_CODE_96     = 8'h54;
   localparam logic [23:0] ROM_BASE       = 24'h008000;
   localparam logic [23:0] ROM_72_BANKS   = 24'h120000;
   localparam logic [23:0] ROM_80_BANKS   = 24'h140000;
   localparam logic [23:0] ROM_96_BANKS   = 24'h180000;
   localparam logic [23:0] ROM_1M         = 24'h100000;

   localparam logic [7:0] RAM_CODE_NONE   = 8'h00;
   localparam logic [7:0] RAM_CODE_2K     = 8'h01;
   localparam logic [7:0] RAM_CODE_8K     = 8'h02;
   localparam logic [7:0] RAM_CODE_32K    = 8'h03;
   localparam logic [7:0] RAM_CODE_128K   = 8'h04;
   localparam logic [7:0] RAM_CODE_64K    = 8'h05;

   localparam logic [7:0] COLOR_REQ_MASK  = 8'h80;
   localparam logic [7:0] COLOR_ENH_MASK  = 8'h40;

   localparam logic [7:0] LOGO_TABLE [48] = '{
      8'hCE, 8'hED, 8'h66, 8'h66, 8'hCC, 8'h0D, 8'h00, 8'h0B,
      8'h03, 8'h73, 8'h00, 8'h83, 8'h00, 8'h0C, 8'h00, 8'h0D,
      8'h00, 8'h08, 8'h11, 8'h1F, 8'h88, 8'h89, 8'h00, 8'h0E,
      8'hDC, 8'hCC, 8'h6E, 8'hE6, 8'hDD, 8'hDD, 8'hD9, 8'h99,
      8'hBB, 8'hBB, 8'h67, 8'h63, 8'h6E, 8'h0E, 8'hEC, 8'hCC,
      8'hDD, 8'hDC, 8'h99, 8'h9F, 8'hBB, 8'hB9, 8'h33, 8'h3E
   };

   // captured header state
   typedef struct packed {
      logic [7:0] checksum_acc;
      logic       logo_bad;
      logic [7:0] stored_sum;
      logic [7:0] cart_kind;
      logic [7:0] rom_code;
      logic [7:0] ram_code;
      logic [1:0] color_bits;
   } hdr_state_type;

   typedef struct packed {
      logic [1:0]  color_support;
      logic [17:0] ram_bytes;
      logic [23:0] rom_bytes;
      status_type  status;
   } verdict_type;

endpackage

/* src/chv_judge.sv */
// ----------------------------------------------------------------------------
// Header verdict
// Turns the captured header state into status, sizes and color class.
// ----------------------------------------------------------------------------
module chv_judge (
   input  chv_pkg::hdr_state_type hdr,
   output chv_pkg::verdict_type   verdict
);
   import chv_pkg::*;

   logic [23:0] rom_size;
   logic        rom_ok;
   logic [17:0] ram_size;
   logic        ram_ok;
   logic        special_kind;
   logic [17:0] ram_final;
   logic [1:0]  color;

   always_comb begin
      rom_ok   = 1'b1;
      rom_size = '0;
      if (hdr.rom_code <= ROM_CODE_MAX) begin
         rom_size = ROM_BASE << hdr.rom_code[3:0];
      end else begin
         case (hdr.rom_code)
            ROM_CODE_72: rom_size = ROM_72_BANKS;
            ROM_CODE_80: rom_size = ROM_80_BANKS;
            ROM_CODE_96: rom_size = ROM_96_BANKS;
            default:     rom_ok   = 1'b0;
         endcase
      end
   end

   always_comb begin
      ram_ok = 1'b1;
      case (hdr.ram_code)
         RAM_CODE_NONE: ram_size = 18'd0;
         RAM_CODE_2K:   ram_size = 18'd2048;
         RAM_CODE_8K:   ram_size = 18'd8192;
         RAM_CODE_32K:  ram_size = 18'd32768;
         RAM_CODE_128K: ram_size = 18'd131072;
         RAM_CODE_64K:  ram_size = 18'd65536;
         default: begin
            ram_size = 18'd0;
            ram_ok   = 1'b0;
         end
      endcase
   end

   assign special_kind = (hdr.cart_kind == KIND_MBC2) || (hdr.cart_kind == KIND_MBC7);

   always_comb begin
      if (!special_kind)
         ram_final = ram_size;
      else if (hdr.cart_kind == KIND_MBC2 || rom_size == ROM_1M)
         ram_final = 18'd256;
      else
         ram_final = 18'd512;
   end

   assign color = !hdr.color_bits[1] ? 2'd0 : (!hdr.color_bits[0] ? 2'd1 : 2'd2);

   always_comb begin
      verdict = '0;
      if (hdr.logo_bad)
         verdict.status = STATUS_LOGO;
      else if (hdr.checksum_acc != hdr.stored_sum)
         verdict.status = STATUS_CHECKSUM;
      else if (!rom_ok)
         verdict.status = STATUS_ROM_CODE;
      else if (!ram_ok)
         verdict.status = STATUS_RAM_CODE;
      else if (special_kind && ram_size != 18'd0)
         verdict.status = STATUS_RAM_CONF;
      else begin
         verdict.status        = STATUS_OK;
         verdict.rom_bytes     = rom_size;
         verdict.ram_bytes     = ram_final;
         verdict.color_support = color;
      end
   end

endmodule

/* src/cart_header_validator.sv */
// ----------------------------------------------------------------------------
// Cartridge header validator
// Checks logo, checksum and size codes of a streamed header; one verdict per
// header on the byte flagged tlast.
// ----------------------------------------------------------------------------
// Throughput: one header byte per cycle, except while a tlast byte waits on a pending verdict.
// A tlast byte passes the input register, then one update/decode pass into the result
//   register, which drives its verdict on rsp.
// A waiting verdict stalls req only when another tlast byte must retire.
// Reset: synchronous, clears the captured header state and both valid flags.
// ----------------------------------------------------------------------------
`include "cart_header_validator_assert.svh"

module cart_header_validator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] header_byte, [14:8] byte_index, [15] zero
   input  logic        req_tlast,   // end_of_header
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // [2:0] status, [26:3] rom_bytes, [44:27] ram_bytes,
                                    // [46:45] color_support, [47] zero
);
   import chv_pkg::*;

   logic          s1_valid_ff;
   logic [7:0]    s1_byte_ff;
   logic [6:0]    s1_index_ff;
   logic          s1_last_ff;
   logic          s1_fire;
   hdr_state_type hdr_ff;
   hdr_state_type hdr_in;
   verdict_type   verdict;
   logic          rsp_valid_ff;
   verdict_type   rsp_data_ff;
   logic [6:0]    logo_off;
   logic [7:0]    sum_step;

   // a plain byte always retires; a tlast byte needs room in the result register
   assign s1_fire    = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         s1_byte_ff  <= req_tdata[7:0];
         s1_index_ff <= req_tdata[14:8];
         s1_last_ff  <= req_tlast;
      end
   end

   assign logo_off = s1_index_ff - IDX_LOGO_FIRST;
   assign sum_step = s1_byte_ff + 8'd1;

   always_comb begin
      hdr_in = hdr_ff;
      if (s1_index_ff >= IDX_LOGO_FIRST && s1_index_ff <= IDX_LOGO_LAST) begin
         if (s1_byte_ff != LOGO_TABLE[logo_off[5:0]])
            hdr_in.logo_bad = 1'b1;
      end
      if (s1_index_ff >= IDX_SUM_FIRST && s1_index_ff <= IDX_SUM_LAST)
         hdr_in.checksum_acc = hdr_ff.checksum_acc - sum_step;
      case (s1_index_ff)
         IDX_COLOR: hdr_in.color_bits = {(s1_byte_ff & COLOR_REQ_MASK) != 8'd0,
                                         (s1_byte_ff & COLOR_ENH_MASK) != 8'd0};
         IDX_KIND:       hdr_in.cart_kind  = s1_byte_ff;
         IDX_ROM_CODE:   hdr_in.rom_code   = s1_byte_ff;
         IDX_RAM_CODE:   hdr_in.ram_code   = s1_byte_ff;
         IDX_STORED_SUM: hdr_in.stored_sum = s1_byte_ff;
         default: ;
      endcase
   end

   chv_judge u_judge (
      .hdr     (hdr_in),
      .verdict (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_fire)
            hdr_ff <= s1_last_ff ? '0 : hdr_in;
         if (s1_fire && s1_last_ff)
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;
      end
      if (s1_fire && s1_last_ff)
         rsp_data_ff <= verdict;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

   `CHV_ASSERT_IMPL(a_fail_zeroes, rsp_valid_ff && rsp_data_ff.status != STATUS_OK, rsp_data_ff.rom_bytes == 24'd0 && rsp_data_ff.ram_bytes == 18'd0 && rsp_data_ff.color_support == 2'd0, "failed verdict carries nonzero sizes")
   `CHV_ASSERT_NEXT(a_last_gives_rsp, s1_fire && s1_last_ff, rsp_valid_ff, "tlast byte retired without a verdict")
   `CHV_ASSERT_NEXT(a_last_clears, s1_fire && s1_last_ff, hdr_ff == '0, "header state not cleared after verdict")
   `CHV_ASSERT_IMPL(a_no_overwrite, rsp_valid_ff && !rsp_tready, !(s1_fire && s1_last_ff), "pending verdict overwritten")

endmodule

/* tb/header_verdict_checker.sv */
// ----------------------------------------------------------------------------
// Header verdict checker
// Watches the request and result streams of the header validator. Each
// accepted request byte updates a local copy of the header state. A tlast
// request turns that state into an expected verdict. Each verdict that
// leaves the block is compared, field by field, with the oldest expected one.
// ----------------------------------------------------------------------------
module header_verdict_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] header_byte, [14:8] byte_index, [15] zero
   input  logic        req_tlast,   // end_of_header
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,   // [2:0] status, [26:3] rom_bytes, [44:27] ram_bytes,
                                    // [46:45] color_support, [47] zero
   output int          verdicts_due,
   output int          mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import chv_pkg::*;

   localparam int MAX_REPORTS = 10;

   hdr_state_type hdr;
   verdict_type   expected_verdicts[$];

   function automatic hdr_state_type absorb_byte(hdr_state_type s, logic [7:0] value,
                                                 logic [6:0] offset);
      hdr_state_type n;
      n = s;
      if (offset >= IDX_LOGO_FIRST && offset <= IDX_LOGO_LAST &&
          value != LOGO_TABLE[offset - IDX_LOGO_FIRST])
         n.logo_bad = 1'b1;
      if (offset >= IDX_SUM_FIRST && offset <= IDX_SUM_LAST)
         n.checksum_acc = s.checksum_acc - (8'd1 + value);
      case (offset)
         IDX_COLOR: begin
            n.color_bits = {(value & COLOR_REQ_MASK) != 8'h00,
                            (value & COLOR_ENH_MASK) != 8'h00};
         end
         IDX_KIND:       n.cart_kind = value;
         IDX_ROM_CODE:   n.rom_code = value;
         IDX_RAM_CODE:   n.ram_code = value;
         IDX_STORED_SUM: n.stored_sum = value;
         default: ;
      endcase
      return n;
   endfunction

   function automatic verdict_type grade_header(hdr_state_type s);
      verdict_type v;
      status_type  st;
      logic [23:0] rom;
      logic [17:0] ram;
      v = '0;
      st = STATUS_OK;
      rom = '0;
      ram = '0;
      if (s.logo_bad) begin
         st = STATUS_LOGO;
      end else if (s.checksum_acc != s.stored_sum) begin
         st = STATUS_CHECKSUM;
      end else begin
         if (s.rom_code <= ROM_CODE_MAX)
            rom = ROM_BASE << s.rom_code;
         else if (s.rom_code == ROM_CODE_72)
            rom = ROM_72_BANKS;
         else if (s.rom_code == ROM_CODE_80)
            rom = ROM_80_BANKS;
         else if (s.rom_code == ROM_CODE_96)
            rom = ROM_96_BANKS;
         else
            st = STATUS_ROM_CODE;

         if (st == STATUS_OK) begin
            case (s.ram_code)
               RAM_CODE_NONE:  ram = 18'd0;
               RAM_CODE_2K:    ram = 18'd2048;
               RAM_CODE_8K:    ram = 18'd8192;
               RAM_CODE_32K:   ram = 18'd32768;
               RAM_CODE_128K:  ram = 18'd131072;
               RAM_CODE_64K:   ram = 18'd65536;
               default:        st = STATUS_RAM_CODE;
            endcase
         end
         // these two kinds carry their own save RAM and must declare none
         if (st == STATUS_OK && (s.cart_kind == KIND_MBC2 || s.cart_kind == KIND_MBC7)) begin
            if (ram != '0)
               st = STATUS_RAM_CONF;
            else if (s.cart_kind == KIND_MBC2)
               ram = 18'd256;
            else
               ram = (rom == ROM_1M) ? 18'd256 : 18'd512;
         end
         if (st == STATUS_OK) begin
            v.color_support = s.color_bits[1] ? (s.color_bits[0] ? 2'd2 : 2'd1) : 2'd0;
         end else begin
            rom = '0;
            ram = '0;
         end
      end
      v.status = st;
      v.rom_bytes = rom;
      v.ram_bytes = ram;
      return v;
   endfunction

   always @(posedge clock) begin : monitor
      verdict_type got;
      verdict_type want;
      if (reset) begin
         hdr = '0;
         expected_verdicts.delete();
         mismatch_count = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            hdr = absorb_byte(hdr, req_tdata[7:0], req_tdata[14:8]);
            if (req_tlast) begin
               expected_verdicts.push_back(grade_header(hdr));
               hdr = '0;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got = verdict_type'(rsp_tdata[46:0]);
            if (expected_verdicts.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: verdict with no header pending: %s %0d rom %0h ram %0h color %0d",
                           $realtime, "status", got.status, got.rom_bytes,
                           got.ram_bytes, got.color_support);
            end else begin
               want = expected_verdicts.pop_front();
               if (got.status != want.status || got.rom_bytes != want.rom_bytes ||
                   got.ram_bytes != want.ram_bytes ||
                   got.color_support != want.color_support) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display({"%0t: verdict mismatch: ",
                               "exp status %0d rom %0h ram %0h color %0d, ",
                               "got status %0d rom %0h ram %0h color %0d"},
                              $realtime, want.status, want.rom_bytes, want.ram_bytes,
                              want.color_support, got.status, got.rom_bytes,
                              got.ram_bytes, got.color_support);
               end
            end
         end
      end
      verdicts_due <= expected_verdicts.size();
   end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// Header validator testbench
// Streams cartridge headers into the validator: a few directed headers, then
// random full headers, sparse headers with mostly valid checksums and plain noise,
// under several sender idle and receiver stall mixes. Checking is done by
// the verdict checker beside the block.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import chv_pkg::*;

   localparam int RANDOM_ITEMS = 850;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int HEADER_LEN   = 80;
   localparam int SEND_IDLE_PCT [4] = '{0, 66, 0, 38};
   localparam int RSP_STALL_PCT [4] = '{0, 0, 66, 38};

   typedef struct packed {
      logic [7:0] value;
      logic [6:0] offset;
   } hdr_byte_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // [7:0] header_byte, [14:8] byte_index, [15] zero
   logic        req_tlast = 1'b0;  // end_of_header
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // [2:0] status, [26:3] rom_bytes, [44:27] ram_bytes,
                                   // [46:45] color_support, [47] zero
   int          verdicts_due;
   int          mismatch_count;

   int           send_idle_pct = 0;
   int           rsp_stall_pct = 0;
   int           items_sent = 0;
   hdr_byte_type hdr_q[$];

   cart_header_validator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   header_verdict_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .verdicts_due   (verdicts_due),
      .mismatch_count (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic push_byte(input logic [7:0] value, input logic [6:0] offset,
                            input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, offset, value};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_header();
      foreach (hdr_q[i])
         push_byte(hdr_q[i].value, hdr_q[i].offset, i == hdr_q.size() - 1);
      hdr_q.delete();
   endtask

   // capture bytes land at random places, so their order varies
   task automatic queue_captures(input logic [7:0] kind, input logic [7:0] rom,
                                 input logic [7:0] ram, input logic [7:0] color,
                                 input int keep_pct);
      hdr_byte_type cap[4];
      cap[0] = '{color, IDX_COLOR};
      cap[1] = '{kind, IDX_KIND};
      cap[2] = '{rom, IDX_ROM_CODE};
      cap[3] = '{ram, IDX_RAM_CODE};
      foreach (cap[i])
         if ($urandom_range(99) < keep_pct)
            hdr_q.insert($urandom_range(hdr_q.size()), cap[i]);
   endtask

   task automatic seal_checksum(input bit corrupt);
      logic [7:0] acc;
      acc = '0;
      foreach (hdr_q[i])
         if (hdr_q[i].offset >= IDX_SUM_FIRST && hdr_q[i].offset <= IDX_SUM_LAST)
            acc = acc - (8'd1 + hdr_q[i].value);
      if (corrupt)
         acc = acc ^ 8'($urandom_range(1, 255));
      foreach (hdr_q[i])
         if (hdr_q[i].offset == IDX_STORED_SUM)
            hdr_q[i] = '{acc, IDX_STORED_SUM};
   endtask

   task automatic close_header(input bit corrupt);
      hdr_q.push_back('{8'h00, IDX_STORED_SUM});
      seal_checksum(corrupt);
   endtask

   task automatic queue_random_header();
      int         r;
      int         n;
      logic [7:0] kind;
      logic [7:0] rom;
      logic [7:0] ram;
      logic [7:0] color;
      logic [7:0] value;
      logic [6:0] offset;
      r = $urandom_range(9);
      kind = (r < 4) ? (r[0] ? KIND_MBC2 : KIND_MBC7) : 8'($urandom);
      r = $urandom_range(9);
      rom = (r < 6) ? 8'($urandom_range(ROM_CODE_MAX)) :
            (r < 8) ? 8'($urandom_range(ROM_CODE_72, ROM_CODE_96)) : 8'($urandom);
      r = $urandom_range(9);
      ram = (r < 7) ? 8'($urandom_range(RAM_CODE_64K)) : 8'($urandom);
      color = 8'($urandom);
      r = $urandom_range(9);
      if (r == 0) begin
         // complete header in address order
         for (int i = 0; i < HEADER_LEN; i++) begin
            offset = 7'(i);
            value = 8'($urandom);
            if (offset >= IDX_LOGO_FIRST && offset <= IDX_LOGO_LAST)
               value = LOGO_TABLE[offset - IDX_LOGO_FIRST];
            case (offset)
               IDX_COLOR:    value = color;
               IDX_KIND:     value = kind;
               IDX_ROM_CODE: value = rom;
               IDX_RAM_CODE: value = ram;
               default: ;
            endcase
            hdr_q.push_back('{value, offset});
         end
         if ($urandom_range(7) == 0) begin
            n = $urandom_range(IDX_LOGO_FIRST, IDX_LOGO_LAST);
            hdr_q[n] = '{hdr_q[n].value ^ 8'($urandom_range(1, 255)), hdr_q[n].offset};
         end
         seal_checksum($urandom_range(9) == 0);
      end else if (r <= 7) begin
         // sparse header: a few stray bytes with the captures mixed in, then the stored sum
         n = $urandom_range(6);
         repeat (n) begin
            r = $urandom_range(9);
            if (r < 4) begin
               offset = 7'($urandom_range(IDX_LOGO_FIRST, IDX_LOGO_LAST));
               value = ($urandom_range(9) == 0) ? 8'($urandom) :
                       LOGO_TABLE[offset - IDX_LOGO_FIRST];
            end else if (r < 6) begin
               offset = 7'($urandom_range(IDX_SUM_FIRST, IDX_SUM_LAST));
               value = 8'($urandom);
            end else begin
               offset = 7'($urandom);
               value = 8'($urandom);
            end
            hdr_q.push_back('{value, offset});
         end
         queue_captures(kind, rom, ram, color, 90);
         close_header($urandom_range(9) == 0);
      end else begin
         repeat ($urandom_range(1, 8))
            hdr_q.push_back('{8'($urandom), 7'($urandom)});
      end
   endtask

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      int base_items;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      base_items = 0;
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = SEND_IDLE_PCT[p];
         rsp_stall_pct = RSP_STALL_PCT[p];
         if (p == 0) begin
            push_byte(8'hFF, 7'h7F, 1'b1);   // offset past the header window
            push_byte(8'h00, 7'h00, 1'b1);   // empty header, all defaults
            push_byte(8'h00, IDX_LOGO_FIRST, 1'b1);
            push_byte(8'hFF, IDX_STORED_SUM, 1'b1);
            queue_captures(KIND_MBC2, ROM_CODE_MAX, RAM_CODE_NONE, 8'hC0, 100);
            close_header(1'b0);
            send_header();
            queue_captures(KIND_MBC7, 8'h05, RAM_CODE_NONE, 8'h80, 100);
            close_header(1'b0);
            send_header();
            queue_captures(KIND_MBC7, ROM_CODE_72, RAM_CODE_32K, 8'h40, 100);
            close_header(1'b0);
            send_header();
            queue_captures(8'hFF, 8'h09, 8'hFF, 8'hFF, 100);
            close_header(1'b0);
            send_header();
            base_items = items_sent;
         end
         while (items_sent < base_items + (p + 1) * RANDOM_ITEMS / 4) begin
            queue_random_header();
            send_header();
         end
         // hold requests until every verdict of this phase is out
         req_tvalid <= 1'b0;
         do @(posedge clock); while (verdicts_due != 0);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && verdicts_due == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+src
src/chv_pkg.sv
src/chv_judge.sv
src/cart_header_validator.sv
tb/header_verdict_checker.sv
tb/tb_top.sv
